// ----- hw/rtl/tbit_pkg.sv -----
// Shared types and constants for the time base and interval timers block.
// No dependencies; imported by tbit_divider and the top level of the block.
`default_nettype none

package tbit_pkg;

    // input item function codes
    localparam logic [2:0] FUNC_ADVANCE    = 3'd0;
    localparam logic [2:0] FUNC_WRITE_PIT  = 3'd1;
    localparam logic [2:0] FUNC_WRITE_STAT = 3'd2;
    localparam logic [2:0] FUNC_WRITE_TBL  = 3'd3;
    localparam logic [2:0] FUNC_WRITE_TBU  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_PIT_IRQ_EN  = 3'd0;
    localparam logic [2:0] CFG_FIT_IRQ_EN  = 3'd1;
    localparam logic [2:0] CFG_AUTO_RELOAD = 3'd2;
    localparam logic [2:0] CFG_FIT_PERIOD  = 3'd3;

    // watched time base bit = FIT_BASE_BIT + 4 * period select
    localparam logic [4:0] FIT_BASE_BIT = 5'd8;

    localparam int DIV_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tbit_divider.sv -----
// Serial restoring divider, one quotient bit per cycle, remainder only.
// Depends on tbit_pkg.
`default_nettype none

module tbit_divider (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire tbit_pkg::div_ctrl_t      ctrl,
    input  wire logic [tbit_pkg::DIV_W-1:0] dividend,
    input  wire logic [tbit_pkg::DIV_W-1:0] divisor,
    output tbit_pkg::div_stat_t           stat,
    output logic [tbit_pkg::DIV_W-1:0]    remainder
);
    import tbit_pkg::*;

    logic [DIV_W-1:0]     dvd_reg;
    logic [DIV_W-1:0]     dsr_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    always_comb begin
        trial = {rem_reg, dvd_reg[DIV_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (!diff[DIV_W]) begin
            rem_next = diff[DIV_W-1:0];
        end else begin
            rem_next = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            cnt_reg <= DIV_CNT_W'(DIV_W - 1);
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/time_base_interval_timers_top.sv -----
// Top level: time base, interval timers, sequencer and result register.
// Depends on tbit_pkg and tbit_divider.
//
//  channel | ports                                   | dir
//  s_      | s_valid s_ready s_func s_tick_count ... | in
//  m_      | m_valid m_ready m_time_base_now ...     | out
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// Writes and advances without reload go through capture, update and result
// load. An advance that expires the timer with auto reload runs the 32-step
// serial divider for the overshoot modulo. One item at a time; s_ready is
// low until the result is loaded into the output register. A stalled result
// holds there while the next item is taken. Reset is synchronous and needs
// no clearing pass.
`default_nettype none

module time_base_interval_timers_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [31:0] s_tick_count,
    input  wire logic [31:0] s_write_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_time_base_now,
    output logic [31:0]      m_pit_count_now,
    output logic             m_pit_status_now,
    output logic             m_fit_status_now,
    output logic             m_pit_irq,
    output logic             m_fit_irq,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import tbit_pkg::*;

    state_t      state_reg, state_next;

    logic        pit_irq_en_reg;
    logic        fit_irq_en_reg;
    logic        auto_reload_reg;
    logic [1:0]  fit_sel_reg;

    logic [63:0] time_base_reg;
    logic [31:0] pit_counter_reg;
    logic [31:0] pit_reload_reg;
    logic        pit_status_reg;
    logic        fit_status_reg;

    logic [2:0]  func_reg;
    logic [31:0] tick_reg;
    logic [31:0] wval_reg;

    logic        m_valid_reg;
    logic        out_free;
    logic        load_out;

    logic [63:0] tb_sum;
    logic [31:0] over;
    logic        expire;
    logic        need_div;
    logic [4:0]  fit_idx;
    logic        fit_rise;

    div_ctrl_t   div_ctrl;
    div_stat_t   div_stat;
    logic [31:0] div_rem;

    tbit_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (over),
        .divisor   (pit_reload_reg),
        .stat      (div_stat),
        .remainder (div_rem)
    );

    always_comb begin
        tb_sum   = time_base_reg + {32'd0, tick_reg};
        over     = tick_reg - pit_counter_reg;
        expire   = (pit_counter_reg != '0) && (tick_reg >= pit_counter_reg);
        need_div = (func_reg == FUNC_ADVANCE) && expire && auto_reload_reg
                   && (pit_reload_reg != '0);
        fit_idx  = FIT_BASE_BIT + {1'b0, fit_sel_reg, 2'b00};
        fit_rise = !time_base_reg[fit_idx] && tb_sum[fit_idx];
        out_free = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        div_ctrl.start = 1'b0;
        load_out       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (need_div) begin
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIV;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            tick_reg <= s_tick_count;
            wval_reg <= s_write_value;
        end
    end

    // timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_base_reg   <= '0;
            pit_counter_reg <= '0;
            pit_reload_reg  <= '0;
            pit_status_reg  <= 1'b0;
            fit_status_reg  <= 1'b0;
        end else if (state_reg == ST_CALC) begin
            case (func_reg)
                FUNC_ADVANCE: begin
                    time_base_reg <= tb_sum;
                    if (expire) begin
                        pit_status_reg <= 1'b1;
                        if (!need_div) begin
                            pit_counter_reg <= '0;
                        end
                    end else if (pit_counter_reg != '0) begin
                        pit_counter_reg <= pit_counter_reg - tick_reg;
                    end
                    if (fit_rise) begin
                        fit_status_reg <= 1'b1;
                    end
                end
                FUNC_WRITE_PIT: begin
                    pit_counter_reg <= wval_reg;
                    pit_reload_reg  <= wval_reg;
                end
                FUNC_WRITE_STAT: begin
                    pit_status_reg <= wval_reg[0];
                    fit_status_reg <= wval_reg[1];
                end
                FUNC_WRITE_TBL: time_base_reg[31:0]  <= wval_reg;
                FUNC_WRITE_TBU: time_base_reg[63:32] <= wval_reg;
                default: ;
            endcase
        end else if (state_reg == ST_DIV && div_stat.done) begin
            pit_counter_reg <= pit_reload_reg - div_rem;
        end
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pit_irq_en_reg  <= 1'b0;
            fit_irq_en_reg  <= 1'b0;
            auto_reload_reg <= 1'b0;
            fit_sel_reg     <= 2'd0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PIT_IRQ_EN:  pit_irq_en_reg  <= cfg_data[0];
                CFG_FIT_IRQ_EN:  fit_irq_en_reg  <= cfg_data[0];
                CFG_AUTO_RELOAD: auto_reload_reg <= cfg_data[0];
                CFG_FIT_PERIOD:  fit_sel_reg     <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_time_base_now  <= time_base_reg;
            m_pit_count_now  <= pit_counter_reg;
            m_pit_status_now <= pit_status_reg;
            m_fit_status_now <= fit_status_reg;
            m_pit_irq        <= pit_status_reg & pit_irq_en_reg;
            m_fit_irq        <= fit_status_reg & fit_irq_en_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tbit_checker.sv -----
// Port-level checks for time_base_interval_timers_top, bound to it below.
// Depends on the top level's port names only.
`default_nettype none

module tbit_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_time_base_now,
    input wire logic [31:0] m_pit_count_now,
    input wire logic        m_pit_status_now,
    input wire logic        m_fit_status_now,
    input wire logic        m_pit_irq,
    input wire logic        m_fit_irq
);

    // one item in flight: no second transfer right after one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_time_base_now)
            && $stable(m_pit_count_now) && $stable(m_pit_status_now)
            && $stable(m_fit_status_now))
        else $error("stalled result changed");

    a_pit_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pit_irq |-> m_pit_status_now)
        else $error("pit irq without pit status");

    a_fit_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fit_irq |-> m_fit_status_now)
        else $error("fit irq without fit status");

endmodule

bind time_base_interval_timers_top tbit_checker u_tbit_checker (.*);

`default_nettype wire

// ----- bench/tbit_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for time_base_interval_timers_top: mirrors the time base and
// timer state, predicts one result per input transfer and compares in order.
// Depends on tbit_pkg for function codes and register indexes.
module tbit_result_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [31:0] s_tick_count,
    input  wire logic [31:0] s_write_value,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [63:0] m_time_base_now,
    input  wire logic [31:0] m_pit_count_now,
    input  wire logic        m_pit_status_now,
    input  wire logic        m_fit_status_now,
    input  wire logic        m_pit_irq,
    input  wire logic        m_fit_irq,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               outstanding
);
    import tbit_pkg::*;

    typedef struct {
        logic [63:0] time_base;
        logic [31:0] pit_count;
        logic        pit_status;
        logic        fit_status;
        logic        pit_irq;
        logic        fit_irq;
    } timer_result_t;

    logic [63:0] tb_model;
    logic [31:0] pit_cnt;
    logic [31:0] pit_rld;
    logic        pit_st;
    logic        fit_st;
    logic        pit_ie;
    logic        fit_ie;
    logic        auto_rld;
    logic [1:0]  fit_sel;

    timer_result_t expected_results[$];

    function automatic timer_result_t step_timers(input logic [2:0] func,
                                                  input logic [31:0] ticks,
                                                  input logic [31:0] wv);
        logic [31:0]   old_low;
        logic [31:0]   watch;
        logic [31:0]   over;
        timer_result_t r;
        case (func)
            FUNC_ADVANCE: begin
                old_low  = tb_model[31:0];
                watch    = 32'd1 << (FIT_BASE_BIT + 4 * fit_sel);
                tb_model = tb_model + {32'd0, ticks};
                if (pit_cnt != 32'd0) begin
                    if (ticks >= pit_cnt) begin
                        over = ticks - pit_cnt;
                        if (auto_rld && pit_rld != 32'd0) begin
                            pit_cnt = pit_rld - (over % pit_rld);
                        end else begin
                            pit_cnt = 32'd0;
                        end
                        pit_st = 1'b1;
                    end else begin
                        pit_cnt = pit_cnt - ticks;
                    end
                end
                if ((~old_low & tb_model[31:0] & watch) != 32'd0) begin
                    fit_st = 1'b1;
                end
            end
            FUNC_WRITE_PIT: begin
                pit_cnt = wv;
                pit_rld = wv;
            end
            FUNC_WRITE_STAT: begin
                pit_st = wv[0];
                fit_st = wv[1];
            end
            FUNC_WRITE_TBL: tb_model[31:0] = wv;
            FUNC_WRITE_TBU: tb_model[63:32] = wv;
            default: ;
        endcase
        r.time_base  = tb_model;
        r.pit_count  = pit_cnt;
        r.pit_status = pit_st;
        r.fit_status = fit_st;
        r.pit_irq    = pit_st & pit_ie;
        r.fit_irq    = fit_st & fit_ie;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        timer_result_t want;
        if (!aresetn) begin
            tb_model   = '0;
            pit_cnt    = '0;
            pit_rld    = '0;
            pit_st     = 1'b0;
            fit_st     = 1'b0;
            pit_ie     = 1'b0;
            fit_ie     = 1'b0;
            auto_rld   = 1'b0;
            fit_sel    = '0;
            fail_count = 0;
            expected_results.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PIT_IRQ_EN:  pit_ie   = cfg_data[0];
                    CFG_FIT_IRQ_EN:  fit_ie   = cfg_data[0];
                    CFG_AUTO_RELOAD: auto_rld = cfg_data[0];
                    CFG_FIT_PERIOD:  fit_sel  = cfg_data[1:0];
                    default: ;
                endcase
            end
            // results leave before this edge's input is queued
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no input item outstanding");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("m_time_base_now", want.time_base, m_time_base_now);
                    check_field("m_pit_count_now", want.pit_count, m_pit_count_now);
                    check_field("m_pit_status_now", want.pit_status, m_pit_status_now);
                    check_field("m_fit_status_now", want.fit_status, m_fit_status_now);
                    check_field("m_pit_irq", want.pit_irq, m_pit_irq);
                    check_field("m_fit_irq", want.fit_irq, m_fit_irq);
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(step_timers(s_func, s_tick_count,
                                                       s_write_value));
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

// ----- bench/tb_time_base_interval_timers_top.sv -----
`timescale 1ns / 1ps
// Testbench top for time_base_interval_timers_top: clock, reset, stimulus
// and verdict. Depends on tbit_pkg, the block and tbit_result_checker.
module tb_time_base_interval_timers_top;
    import tbit_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 225;
    localparam int DRAIN_CYCLES = 40;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_func;
    logic [31:0] s_tick_count;
    logic [31:0] s_write_value;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_time_base_now;
    logic [31:0] m_pit_count_now;
    logic        m_pit_status_now;
    logic        m_fit_status_now;
    logic        m_pit_irq;
    logic        m_fit_irq;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;
    int fail_count;
    int outstanding;

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    time_base_interval_timers_top i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_tick_count     (s_tick_count),
        .s_write_value    (s_write_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_time_base_now  (m_time_base_now),
        .m_pit_count_now  (m_pit_count_now),
        .m_pit_status_now (m_pit_status_now),
        .m_fit_status_now (m_fit_status_now),
        .m_pit_irq        (m_pit_irq),
        .m_fit_irq        (m_fit_irq),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    tbit_result_checker i_results (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_tick_count     (s_tick_count),
        .s_write_value    (s_write_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_time_base_now  (m_time_base_now),
        .m_pit_count_now  (m_pit_count_now),
        .m_pit_status_now (m_pit_status_now),
        .m_fit_status_now (m_fit_status_now),
        .m_pit_irq        (m_pit_irq),
        .m_fit_irq        (m_fit_irq),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    // valid stays high across back-to-back items; only an idle gap or wait_idle lowers it
    task automatic send_item(input logic [2:0] func, input logic [31:0] ticks,
                             input logic [31:0] wv);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid       <= 1'b1;
        s_func        <= func;
        s_tick_count  <= ticks;
        s_write_value <= wv;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // upper data bits are noise; the block must mask them
    task automatic program_timers(input logic pie, input logic fie,
                                  input logic are, input logic [1:0] fsel);
        write_reg(CFG_PIT_IRQ_EN, ($urandom & ~32'd1) | {31'd0, pie});
        write_reg(CFG_FIT_IRQ_EN, ($urandom & ~32'd1) | {31'd0, fie});
        if ($urandom_range(3) == 0) begin
            write_reg(CFG_FIT_PERIOD + 3'($urandom_range(1, 4)), $urandom);
        end
        write_reg(CFG_AUTO_RELOAD, ($urandom & ~32'd1) | {31'd0, are});
        write_reg(CFG_FIT_PERIOD, ($urandom & ~32'd3) | {30'd0, fsel});
        cfg_valid <= 1'b0;
    endtask

    task automatic rand_item();
        logic [2:0]  func;
        logic [31:0] ticks;
        logic [31:0] wv;
        logic [31:0] watch_bit;
        int          pick;
        int          cls;
        pick  = $urandom_range(99);
        cls   = $urandom_range(9);
        ticks = $urandom;
        wv    = $urandom;
        if (pick < 50) begin
            func = FUNC_ADVANCE;
            if (cls == 0) ticks = '0;
            else if (cls <= 5) ticks = $urandom_range(1, 300);
            else if (cls <= 7) ticks = $urandom_range(1, 65535);
            else if (cls == 9) ticks = '1;
        end else if (pick < 65) begin
            func = FUNC_WRITE_PIT;
            if (cls == 0) wv = '0;
            else if (cls <= 5) wv = $urandom_range(1, 500);
            else if (cls <= 7) wv = $urandom_range(1, 100000);
        end else if (pick < 75) begin
            func = FUNC_WRITE_STAT;
        end else if (pick < 85) begin
            func = FUNC_WRITE_TBL;
            if (cls <= 5) begin
                // just below a watched bit so a short advance raises it
                watch_bit = 32'd1 << (FIT_BASE_BIT + 4 * $urandom_range(3));
                wv = (wv & ~((watch_bit << 1) - 32'd1))
                   | (watch_bit - 32'($urandom_range(1, 200)));
            end else if (cls <= 7) begin
                wv = 32'hFFFF_FFFF - 32'($urandom_range(0, 300));
            end
        end else if (pick < 93) begin
            func = FUNC_WRITE_TBU;
            if (cls <= 2) wv = '1;
        end else begin
            func = FUNC_WRITE_TBU + 3'($urandom_range(1, 3));
        end
        send_item(func, ticks, wv);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_func        = '0;
        s_tick_count  = '0;
        s_write_value = '0;
        m_ready       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: no reload, interrupts masked, watch bit 8
        send_item(FUNC_ADVANCE, 32'd0, 32'd0);
        send_item(FUNC_WRITE_PIT, 32'd0, 32'd100);
        send_item(FUNC_ADVANCE, 32'd30, 32'd0);
        send_item(FUNC_ADVANCE, 32'd70, 32'd0);
        send_item(FUNC_ADVANCE, 32'd5, 32'd0);
        send_item(FUNC_WRITE_STAT, 32'd0, 32'hFFFF_FFFC);
        send_item(FUNC_WRITE_STAT, 32'd0, 32'd3);
        send_item(FUNC_WRITE_TBL, 32'd0, 32'hFFFF_FFFF);
        send_item(FUNC_ADVANCE, 32'd1, 32'd0);
        send_item(FUNC_WRITE_TBU, 32'd0, 32'hFFFF_FFFF);
        send_item(FUNC_WRITE_TBL, 32'd0, 32'hFFFF_FFF0);
        send_item(FUNC_ADVANCE, 32'h20, 32'd0);
        send_item(FUNC_WRITE_TBU + 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(FUNC_WRITE_TBU + 3'd2, 32'd0, 32'd0);
        send_item(FUNC_WRITE_TBU + 3'd3, 32'h5A5A_5A5A, 32'hA5A5_A5A5);

        wait_idle();
        program_timers(1'b1, 1'b1, 1'b1, 2'd0);
        send_item(FUNC_WRITE_TBL, 32'd0, 32'h0000_00FF);
        send_item(FUNC_ADVANCE, 32'd1, 32'd0);
        send_item(FUNC_WRITE_STAT, 32'd0, 32'd0);
        send_item(FUNC_WRITE_PIT, 32'd0, 32'd10);
        send_item(FUNC_ADVANCE, 32'd35, 32'd0);
        send_item(FUNC_ADVANCE, 32'hFFFF_FFFF, 32'd0);
        send_item(FUNC_WRITE_PIT, 32'd0, 32'd1);
        send_item(FUNC_ADVANCE, 32'hFFFF_FFFF, 32'd0);
        send_item(FUNC_WRITE_PIT, 32'd0, 32'hFFFF_FFFF);
        send_item(FUNC_ADVANCE, 32'hFFFF_FFFF, 32'd0);
        send_item(FUNC_WRITE_PIT, 32'd0, 32'd0);
        send_item(FUNC_ADVANCE, 32'd7, 32'd0);

        wait_idle();
        program_timers(1'b0, 1'b0, 1'b0, 2'd3);
        send_item(FUNC_WRITE_TBL, 32'd0, 32'h000F_FFFF);
        send_item(FUNC_ADVANCE, 32'd1, 32'd0);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: program_timers(1'b1, 1'b1, 1'b1, 2'd3);
                1: program_timers(1'b0, 1'b0, 1'b0, 2'd0);
                default: program_timers(1'($urandom_range(1)), 1'($urandom_range(1)),
                                        1'($urandom_range(1)), 2'($urandom_range(3)));
            endcase
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 72; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 72; end
                default: begin idle_pct = 31; stall_pct <= 31; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                rand_item();
                if ($urandom_range(199) == 0) wait_idle();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
